// ----- rtl/lap_pkg.sv -----
// Shared types, widths and codes of the five-point Laplacian block.
`timescale 1ns / 1ps

package lap_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int LAP_BITS       = SAMPLE_BITS + 3;
  localparam int COL_BITS       = 12;
  localparam int ROW_BITS       = 16;
  localparam int MAX_WIDTH      = 4096;
  localparam int LINE_DEPTH     = 2 * MAX_WIDTH;
  localparam int ADDR_BITS      = $clog2(LINE_DEPTH);
  localparam int WIDTH_BITS     = 13;
  localparam int HEIGHT_BITS    = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam int IN_TDATA_BITS  = 16;
  localparam int OUT_FIELD_BITS = LAP_BITS + COL_BITS + ROW_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  localparam cfg_index_t REG_IMAGE_WIDTH  = cfg_index_t'(0);
  localparam cfg_index_t REG_IMAGE_HEIGHT = cfg_index_t'(1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [LAP_BITS-1:0]    lap_t;
  typedef logic [COL_BITS-1:0]           col_t;
  typedef logic [ROW_BITS-1:0]           row_t;
  typedef logic [ADDR_BITS-1:0]          addr_t;

  // Which neighbor of the current sample a result belongs to.
  typedef enum logic [1:0] {
    EM_INNER,     // (col-1, row-1)
    EM_LAST_COL,  // (col,   row-1), current sample ends its row
    EM_LAST_ROW,  // (col-1, row),   current row is the bottom row
    EM_CORNER     // (col,   row),   bottom row and last column
  } emit_kind_t;

  localparam int EMIT_KINDS = 4;

  // One classified sample, as handed from the front to the back.
  typedef struct packed {
    sample_t                now;
    sample_t                prev0;
    sample_t                prev1;
    col_t                   col;
    row_t                   row;
    logic [EMIT_KINDS-1:0]  emit;
    logic                   col_ge2;
    logic                   row_ge2;
    logic                   col_pos;
    logic                   col_end;
    logic                   refill;
  } op_t;

  typedef enum logic [1:0] {
    ISS_HEAD,
    ISS_FILL2,
    ISS_MAIN
  } iss_state_t;

  typedef enum logic [1:0] {
    RD_FILL1,
    RD_FILL2,
    RD_MAIN
  } rd_kind_t;

endpackage

// ----- rtl/laplacian_5point_stencil.sv -----
// Top level of the streaming five-point Laplacian block.
`timescale 1ns / 1ps

// Streaming five-point Laplacian over a raster image.
// Channels: cfg (valid/ready, index, data) writes image_width (index 0) and
// image_height (index 1); cfg_ready is always high, other indexes are dropped.
// Write it only while the block is idle. s_axis takes one signed sample per
// word in raster order. m_axis gives one result per word: the Laplacian of a
// pixel with its column and row; tlast marks the final result caused by one
// input sample (zero to four results per sample).
// Throughput: one sample per cycle while the queue has room. The output
// register moves one result per cycle while m_tready is high, so a sample
// with two results holds the output longer than one with a single result,
// and a bottom-right corner sample with four longer still. The four-word
// queue absorbs a row end; along the bottom row each sample past column zero
// has two or more results, so once the queue fills s_tready drops there.
// Path: queue, line-store read, operand stage, output register. A sample
// clamped after a size change first refills the window from the line store.
// Reset: position counters return to pixel (0,0), width and height to 2.
// The line store is not cleared; every entry is written before it is used.
// Stall: when m_tready is low the result holds; the queue fills and then
// s_tready drops until the receiver drains.

module laplacian_5point_stencil (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  lap_pkg::cfg_index_t                  cfg_index,
  input  logic [lap_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [lap_pkg::IN_TDATA_BITS-1:0]    s_tdata,  // [15:0] sample
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [18:0] laplacian, [30:19] column, [46:31] row, [47] zero
  output logic [lap_pkg::OUT_TDATA_BITS-1:0]   m_tdata,
  output logic                                 m_tlast
);

  logic         q_full;
  logic         push;
  lap_pkg::op_t push_op;
  logic         pop;
  logic         head_valid;
  lap_pkg::op_t head_op;

  // Registers take every write at once.
  assign cfg_ready = 1'b1;

  // Track the raster position and tag each sample with the results it causes.
  lap_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_op   (push_op)
  );

  // Decouple intake from the line store and result serializer.
  lap_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  // Read the two rows above, form the stencil and emit results one by one.
  lap_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

// ----- rtl/lap_front.sv -----
// Front end: configuration registers, raster position tracking and sample classification.
`timescale 1ns / 1ps

module lap_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  lap_pkg::cfg_index_t                 cfg_index,
  input  logic [lap_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [lap_pkg::IN_TDATA_BITS-1:0]   s_tdata,
  input  logic                                q_full,
  output logic                                push,
  output lap_pkg::op_t                        push_op
);

  lap_pkg::col_t    w_last;
  lap_pkg::row_t    h_last;
  lap_pkg::col_t    column_count;
  lap_pkg::row_t    row_count;
  lap_pkg::sample_t prev0;
  lap_pkg::sample_t prev1;

  logic [lap_pkg::WIDTH_BITS-1:0]  wv;
  logic [lap_pkg::WIDTH_BITS-1:0]  wv_m1;
  logic [lap_pkg::HEIGHT_BITS-1:0] hv;
  logic [lap_pkg::HEIGHT_BITS-1:0] hv_m1;

  lap_pkg::col_t    col;
  lap_pkg::row_t    row;
  lap_pkg::sample_t now;
  logic             col_pos, row_pos, col_end, row_end;

  assign wv    = cfg_data[lap_pkg::WIDTH_BITS-1:0];
  assign wv_m1 = wv - lap_pkg::WIDTH_BITS'(1);
  assign hv    = cfg_data[lap_pkg::HEIGHT_BITS-1:0];
  assign hv_m1 = hv - lap_pkg::HEIGHT_BITS'(1);

  // Store the last valid column and row index, already clamped.
  always_ff @(posedge clk) begin
    if (rst) begin
      w_last <= lap_pkg::col_t'(1);
      h_last <= lap_pkg::row_t'(1);
    end else if (cfg_valid) begin
      if (cfg_index == lap_pkg::REG_IMAGE_WIDTH) begin
        if (wv < lap_pkg::WIDTH_BITS'(2)) begin
          w_last <= lap_pkg::col_t'(1);
        end else if (wv > lap_pkg::WIDTH_BITS'(lap_pkg::MAX_WIDTH)) begin
          w_last <= lap_pkg::col_t'(lap_pkg::MAX_WIDTH - 1);
        end else begin
          w_last <= wv_m1[lap_pkg::COL_BITS-1:0];
        end
      end else if (cfg_index == lap_pkg::REG_IMAGE_HEIGHT) begin
        if (hv < lap_pkg::HEIGHT_BITS'(2)) begin
          h_last <= lap_pkg::row_t'(1);
        end else begin
          h_last <= hv_m1[lap_pkg::ROW_BITS-1:0];
        end
      end
    end
  end

  assign now     = lap_pkg::sample_t'(s_tdata[lap_pkg::SAMPLE_BITS-1:0]);
  assign col     = (column_count > w_last) ? w_last : column_count;
  assign row     = (row_count > h_last) ? h_last : row_count;
  assign col_pos = (col != '0);
  assign row_pos = (row != '0);
  assign col_end = (col == w_last);
  assign row_end = (row == h_last);

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    push_op                               = '0;
    push_op.now                           = now;
    push_op.prev0                         = prev0;
    push_op.prev1                         = prev1;
    push_op.col                           = col;
    push_op.row                           = row;
    push_op.emit[lap_pkg::EM_INNER]       = row_pos && col_pos;
    push_op.emit[lap_pkg::EM_LAST_COL]    = row_pos && col_end;
    push_op.emit[lap_pkg::EM_LAST_ROW]    = row_end && col_pos;
    push_op.emit[lap_pkg::EM_CORNER]      = row_end && col_end;
    push_op.col_ge2                       = (col > lap_pkg::col_t'(1));
    push_op.row_ge2                       = (row > lap_pkg::row_t'(1));
    push_op.col_pos                       = col_pos;
    push_op.col_end                       = col_end;
    // A clamped position breaks the column sequence: the line window is stale.
    push_op.refill = col_pos && ((column_count != col) || (row_count != row));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (push) begin
      if (col_end) begin
        column_count <= '0;
        row_count    <= row_end ? '0 : row + lap_pkg::row_t'(1);
      end else begin
        column_count <= col + lap_pkg::col_t'(1);
        row_count    <= row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      prev1 <= prev0;
      prev0 <= now;
    end
  end

endmodule

// ----- rtl/lap_queue.sv -----
// Short FIFO of classified samples between the front and the back end.
`timescale 1ns / 1ps

module lap_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lap_pkg::op_t  push_op,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output lap_pkg::op_t  head_op
);

  lap_pkg::op_t                  entries [lap_pkg::QUEUE_DEPTH];
  logic [lap_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [lap_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [lap_pkg::QCNT_BITS-1:0] count;

  assign full       = (count == lap_pkg::QCNT_BITS'(lap_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + lap_pkg::QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + lap_pkg::QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + lap_pkg::QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - lap_pkg::QCNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

// ----- rtl/lap_back.sv -----
// Back end: line store, neighbor window, stencil arithmetic and output register.
`timescale 1ns / 1ps

module lap_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 head_valid,
  input  lap_pkg::op_t                         head_op,
  output logic                                 pop,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [lap_pkg::OUT_TDATA_BITS-1:0]   m_tdata,
  output logic                                 m_tlast
);

  // Issue sequencer.
  lap_pkg::iss_state_t state, state_next;
  lap_pkg::rd_kind_t   iss_kind;
  logic                issue_ok, issue_en, issue_main;

  // Line store ports.
  lap_pkg::sample_t line_mem [lap_pkg::LINE_DEPTH];
  lap_pkg::addr_t   addr_a, addr_b, waddr;
  lap_pkg::sample_t rd_a, rd_b, wdata;
  logic             we;
  logic             par_up, par_cur;
  lap_pkg::col_t    col_m1, col_m2;

  // Deferred write of the last sample of a row.
  logic             pend_valid;
  lap_pkg::addr_t   pend_addr;
  lap_pkg::sample_t pend_data;

  // Read-return stage.
  logic              r_valid, r_adv, r_has_res;
  lap_pkg::rd_kind_t r_kind;
  lap_pkg::op_t      r_op;

  // Window of the two rows above.
  lap_pkg::sample_t win_a2, win_a1, win_b1;

  // Operand stage.
  logic                             s_valid, s_load, s_emit, s_last, s_free;
  logic [lap_pkg::EMIT_KINDS-1:0]   s_mask, mask_rest;
  lap_pkg::sample_t                 s_a2, s_a1, s_a0, s_b1, s_b0;
  lap_pkg::sample_t                 s_now, s_prev0, s_prev1;
  lap_pkg::col_t                    s_col;
  lap_pkg::row_t                    s_row;
  logic                             s_col_ge2, s_row_ge2;
  lap_pkg::emit_kind_t              pick;
  lap_pkg::sample_t                 op_l, op_r, op_u, op_d, op_c;
  lap_pkg::col_t                    e_col;
  lap_pkg::row_t                    e_row;
  lap_pkg::lap_t                    e_lap;

  // Output register.
  logic             o_valid, o_free, o_last;
  lap_pkg::lap_t    o_lap;
  lap_pkg::col_t    o_col;
  lap_pkg::row_t    o_row;

  assign issue_en   = head_valid && issue_ok;
  assign issue_main = issue_en && (iss_kind == lap_pkg::RD_MAIN);

  always_comb begin
    state_next = state;
    unique case (state)
      lap_pkg::ISS_HEAD: begin
        if (issue_en && head_op.refill) begin
          state_next = lap_pkg::ISS_FILL2;
        end
      end
      lap_pkg::ISS_FILL2: begin
        if (issue_en) begin
          state_next = lap_pkg::ISS_MAIN;
        end
      end
      lap_pkg::ISS_MAIN: begin
        if (issue_en) begin
          state_next = lap_pkg::ISS_HEAD;
        end
      end
      default: state_next = lap_pkg::ISS_HEAD;
    endcase
  end

  always_comb begin
    unique case (state)
      lap_pkg::ISS_HEAD:  iss_kind = head_op.refill ? lap_pkg::RD_FILL1 : lap_pkg::RD_MAIN;
      lap_pkg::ISS_FILL2: iss_kind = lap_pkg::RD_FILL2;
      lap_pkg::ISS_MAIN:  iss_kind = lap_pkg::RD_MAIN;
      default:            iss_kind = lap_pkg::RD_MAIN;
    endcase
  end

  assign pop = issue_main;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lap_pkg::ISS_HEAD;
    end else begin
      state <= state_next;
    end
  end

  // Row r-1 lives in the other parity half, rows r and r-2 share one half.
  assign par_up  = ~head_op.row[0];
  assign par_cur = head_op.row[0];
  assign col_m1  = head_op.col - lap_pkg::col_t'(1);
  assign col_m2  = head_op.col - lap_pkg::col_t'(2);

  always_comb begin
    case (iss_kind)
      lap_pkg::RD_FILL1: begin
        addr_a = {par_up, col_m2};
        addr_b = {par_cur, col_m1};
      end
      lap_pkg::RD_FILL2: begin
        addr_a = {par_up, col_m1};
        addr_b = {par_cur, col_m1};
      end
      default: begin
        addr_a = {par_up, head_op.col};
        addr_b = {par_cur, head_op.col};
      end
    endcase
  end

  // The sample after a row end always sits in column zero and writes nothing,
  // so the deferred write never meets a write of its own.
  assign we    = pend_valid || (issue_main && head_op.col_pos);
  assign waddr = pend_valid ? pend_addr : {par_cur, col_m1};
  assign wdata = pend_valid ? pend_data : head_op.prev0;

  always_ff @(posedge clk) begin
    if (issue_en) begin
      rd_a <= line_mem[addr_a];
      rd_b <= line_mem[addr_b];
    end
    if (we) begin
      line_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= issue_main && head_op.col_end;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_main) begin
      pend_addr <= {par_cur, head_op.col};
      pend_data <= head_op.now;
    end
  end

  // Read-return stage: the read data holds while no new read is issued.
  assign r_has_res = (r_op.emit != '0);
  assign r_adv     = r_valid && ((r_kind != lap_pkg::RD_MAIN) || !r_has_res || s_free);
  assign issue_ok  = !r_valid || r_adv;
  assign s_load    = r_adv && (r_kind == lap_pkg::RD_MAIN) && r_has_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (issue_en) begin
      r_valid <= 1'b1;
    end else if (r_adv) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_en) begin
      r_kind <= iss_kind;
      r_op   <= head_op;
    end
  end

  always_ff @(posedge clk) begin
    if (r_adv) begin
      case (r_kind)
        lap_pkg::RD_FILL1: begin
          win_a2 <= rd_a;
          win_b1 <= rd_b;
        end
        lap_pkg::RD_FILL2: begin
          win_a1 <= rd_a;
        end
        default: begin
          win_a2 <= win_a1;
          win_a1 <= rd_a;
          win_b1 <= rd_b;
        end
      endcase
    end
  end

  // Operand stage: one result per cycle while the output is free, in raster order.
  always_comb begin
    if (s_mask[lap_pkg::EM_INNER]) begin
      pick = lap_pkg::EM_INNER;
    end else if (s_mask[lap_pkg::EM_LAST_COL]) begin
      pick = lap_pkg::EM_LAST_COL;
    end else if (s_mask[lap_pkg::EM_LAST_ROW]) begin
      pick = lap_pkg::EM_LAST_ROW;
    end else begin
      pick = lap_pkg::EM_CORNER;
    end
  end

  assign mask_rest = s_mask & ~(lap_pkg::EMIT_KINDS'(1) << pick);
  assign o_free    = !o_valid || m_tready;
  assign s_emit    = s_valid && o_free;
  assign s_last    = (mask_rest == '0);
  assign s_free    = !s_valid || (s_emit && s_last);

  always_comb begin
    unique case (pick)
      lap_pkg::EM_INNER: begin
        op_l  = s_col_ge2 ? s_a2 : '0;
        op_r  = s_a0;
        op_u  = s_row_ge2 ? s_b1 : '0;
        op_d  = s_prev0;
        op_c  = s_a1;
        e_col = s_col - lap_pkg::col_t'(1);
        e_row = s_row - lap_pkg::row_t'(1);
      end
      lap_pkg::EM_LAST_COL: begin
        op_l  = s_a1;
        op_r  = '0;
        op_u  = s_row_ge2 ? s_b0 : '0;
        op_d  = s_now;
        op_c  = s_a0;
        e_col = s_col;
        e_row = s_row - lap_pkg::row_t'(1);
      end
      lap_pkg::EM_LAST_ROW: begin
        op_l  = s_col_ge2 ? s_prev1 : '0;
        op_r  = s_now;
        op_u  = s_a1;
        op_d  = '0;
        op_c  = s_prev0;
        e_col = s_col - lap_pkg::col_t'(1);
        e_row = s_row;
      end
      default: begin
        op_l  = s_prev0;
        op_r  = '0;
        op_u  = s_a0;
        op_d  = '0;
        op_c  = s_now;
        e_col = s_col;
        e_row = s_row;
      end
    endcase
  end

  assign e_lap = lap_pkg::lap_t'(op_l) + lap_pkg::lap_t'(op_r) + lap_pkg::lap_t'(op_u)
               + lap_pkg::lap_t'(op_d) - (lap_pkg::lap_t'(op_c) <<< 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      s_mask  <= '0;
    end else if (s_load) begin
      s_valid <= 1'b1;
      s_mask  <= r_op.emit;
    end else if (s_emit) begin
      s_mask <= mask_rest;
      if (s_last) begin
        s_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_load) begin
      s_a2      <= win_a2;
      s_a1      <= win_a1;
      s_a0      <= rd_a;
      s_b1      <= win_b1;
      s_b0      <= rd_b;
      s_now     <= r_op.now;
      s_prev0   <= r_op.prev0;
      s_prev1   <= r_op.prev1;
      s_col     <= r_op.col;
      s_row     <= r_op.row;
      s_col_ge2 <= r_op.col_ge2;
      s_row_ge2 <= r_op.row_ge2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s_emit) begin
      o_valid <= 1'b1;
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_emit) begin
      o_lap  <= e_lap;
      o_col  <= e_col;
      o_row  <= e_row;
      o_last <= s_last;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tlast  = o_last;
  assign m_tdata  = {{(lap_pkg::OUT_TDATA_BITS - lap_pkg::OUT_FIELD_BITS){1'b0}},
                     o_row, o_col, o_lap};

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the streaming five-point Laplacian block.
`timescale 1ns / 1ps

module tb_top;
  import lap_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 16;   // latency plus refill, with margin
  localparam int REPORT_LIMIT   = 10;

  // Register indexes past the two defined ones; the block drops them.
  localparam cfg_index_t REG_SPARE_2 = cfg_index_t'(2);
  localparam cfg_index_t REG_SPARE_3 = cfg_index_t'(3);

  typedef struct packed {
    lap_t lap;
    col_t col;
    row_t row;
    logic last;
  } lap_result_t;

  typedef enum logic { STIM_SAMPLE, STIM_WRITE } stim_kind_t;

  // One line of the directed table: a sample word or a register write.
  // has_lap marks the sample that closes a 2x2 image; its four results are typed.
  typedef struct packed {
    stim_kind_t               kind;
    cfg_index_t               idx;
    logic [15:0]              data;
    logic                     has_lap;
    logic [3:0][LAP_BITS-1:0] lap;
  } stim_row_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_valid;
  logic                      cfg_ready;
  cfg_index_t                cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [IN_TDATA_BITS-1:0]  s_tdata;   // [15:0] sample
  logic                      m_tvalid;
  logic                      m_tready;
  logic [OUT_TDATA_BITS-1:0] m_tdata;   // [18:0] laplacian, [30:19] column, [46:31] row
  logic                      m_tlast;

  laplacian_5point_stencil DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // Stencil state mirrored from the block.
  int          line_store [LINE_DEPTH];
  int          prev0, prev1;
  int          col_pos, row_pos;
  logic [12:0] width_reg;
  logic [15:0] height_reg;
  int          cur_c, cur_r, cur_v;

  lap_result_t pending_laplacians [$];
  stim_row_t   directed_rows [$];
  int          fail_count = 0;
  int          send_idle_max;
  int          recv_idle_max;
  int          quiet_cycles = 0;
  lap_result_t got_result, want_result;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Stencil prediction
  // ---------------------------------------------------------------------------

  function automatic int pixel_at(input int x, input int y);
    if (y == cur_r) begin
      if (x == cur_c) return cur_v;
      if (x + 1 == cur_c) return prev0;
      if (x + 2 == cur_c) return prev1;
    end
    return line_store[(y % 2) * MAX_WIDTH + (x % MAX_WIDTH)];
  endfunction

  function automatic lap_result_t stencil_at(input int x, input int y, input int w,
                                             input int h);
    int          sum;
    lap_result_t res;
    sum = 0;
    if (x > 0) sum += pixel_at(x - 1, y);
    if (x + 1 < w) sum += pixel_at(x + 1, y);
    if (y > 0) sum += pixel_at(x, y - 1);
    if (y + 1 < h) sum += pixel_at(x, y + 1);
    res.lap  = lap_t'(sum - 4 * pixel_at(x, y));
    res.col  = col_t'(x);
    res.row  = row_t'(y);
    res.last = 1'b0;
    return res;
  endfunction

  // Advance the stencil by one sample; queue its results unless told to drop them.
  task automatic stencil_step(input logic [15:0] v, input bit keep);
    int          w, h, c, r;
    lap_result_t batch [$];
    w = int'(width_reg);
    h = int'(height_reg);
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < 2) h = 2;
    // a counter left beyond a shrunk size acts as the last column or row
    c = (col_pos > w - 1) ? w - 1 : col_pos;
    r = (row_pos > h - 1) ? h - 1 : row_pos;
    cur_c = c;
    cur_r = r;
    cur_v = int'(sample_t'(v));

    if (r >= 1 && c >= 1) batch.push_back(stencil_at(c - 1, r - 1, w, h));
    if (r >= 1 && c == w - 1) batch.push_back(stencil_at(w - 1, r - 1, w, h));
    if (r == h - 1 && c >= 1) batch.push_back(stencil_at(c - 1, r, w, h));
    if (r == h - 1 && c == w - 1) batch.push_back(stencil_at(w - 1, r, w, h));
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    if (keep) foreach (batch[i]) pending_laplacians.push_back(batch[i]);

    // store the previous sample only after this step's reads
    if (c >= 1) line_store[(r % 2) * MAX_WIDTH + c - 1] = prev0;
    if (c == w - 1) line_store[(r % 2) * MAX_WIDTH + c] = cur_v;
    prev1 = prev0;
    prev0 = cur_v;

    if (c == w - 1) begin
      col_pos = 0;
      row_pos = (r == h - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] random_sample();
    logic [15:0] pick [4];
    pick = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    if ($urandom_range(0, 7) == 0) return pick[$urandom_range(0, 3)];
    return 16'($urandom);
  endfunction

  // Offer one sample word, wait for it to be taken, predict its results.
  // Leaves s_tvalid high so a back-to-back word needs no second assignment.
  task automatic feed_sample(input logic [15:0] v, input logic has_lap,
                             input logic [3:0][LAP_BITS-1:0] lap);
    int          gap;
    lap_result_t typed;
    gap = $urandom_range(0, send_idle_max);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    stencil_step(v, !has_lap);
    if (has_lap) begin
      for (int i = 0; i < 4; i++) begin
        typed.lap  = lap[i];
        typed.col  = col_t'(i % 2);
        typed.row  = row_t'(i / 2);
        typed.last = (i == 3);
        pending_laplacians.push_back(typed);
      end
    end
    @(negedge clk);
  endtask

  // Hold the input until every expected word has come out, then let the
  // block finish any sample that causes no result.
  task automatic settle_idle();
    s_tvalid <= 1'b0;
    while (pending_laplacians.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input cfg_index_t idx, input logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_IMAGE_WIDTH) width_reg = v[12:0];
    else if (idx == REG_IMAGE_HEIGHT) height_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic feed_random(input int count);
    for (int i = 0; i < count; i++) begin
      // now and then drain completely before the next word
      if ($urandom_range(0, 63) == 0) settle_idle();
      feed_sample(random_sample(), 1'b0, '0);
    end
  endtask

  // Set the image size, then stream whole images so the counters end at (0,0).
  task automatic run_images(input logic [15:0] w_data, input logic [15:0] h_data);
    int eff_w, eff_h, images;
    eff_w = int'(w_data[12:0]);
    eff_h = int'(h_data);
    if (eff_w < 2) eff_w = 2;
    if (eff_w > MAX_WIDTH) eff_w = MAX_WIDTH;
    if (eff_h < 2) eff_h = 2;
    images = (eff_w * eff_h >= 28) ? 1 : 28 / (eff_w * eff_h);
    settle_idle();
    write_register(REG_IMAGE_WIDTH, w_data);
    write_register(REG_IMAGE_HEIGHT, h_data);
    feed_random(images * eff_w * eff_h);
  endtask

  function automatic stim_row_t sample_row(input logic [15:0] v);
    stim_row_t entry;
    entry      = '0;
    entry.kind = STIM_SAMPLE;
    entry.data = v;
    return entry;
  endfunction

  // Sample that closes a 2x2 image: results (0,0), (1,0), (0,1), (1,1) in order.
  function automatic stim_row_t closing_row(input logic [15:0] v, input int l0,
                                            input int l1, input int l2, input int l3);
    stim_row_t entry;
    entry         = sample_row(v);
    entry.has_lap = 1'b1;
    entry.lap[0]  = lap_t'(l0);
    entry.lap[1]  = lap_t'(l1);
    entry.lap[2]  = lap_t'(l2);
    entry.lap[3]  = lap_t'(l3);
    return entry;
  endfunction

  function automatic stim_row_t write_row(input cfg_index_t idx, input logic [15:0] v);
    stim_row_t entry;
    entry      = '0;
    entry.kind = STIM_WRITE;
    entry.idx  = idx;
    entry.data = v;
    return entry;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the scoreboard
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = $urandom_range(0, recv_idle_max);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_result.lap  = m_tdata[LAP_BITS-1:0];
      got_result.col  = m_tdata[LAP_BITS+COL_BITS-1:LAP_BITS];
      got_result.row  = m_tdata[LAP_BITS+COL_BITS+ROW_BITS-1:LAP_BITS+COL_BITS];
      got_result.last = m_tlast;
      if (pending_laplacians.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected word: lap %0d col %0d row %0d last %0b",
                   got_result.lap, got_result.col, got_result.row, got_result.last);
      end else begin
        want_result = pending_laplacians.pop_front();
        if (got_result !== want_result) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("mismatch (lap col row last): expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                     want_result.lap, want_result.col, want_result.row, want_result.last,
                     got_result.lap, got_result.col, got_result.row, got_result.last);
        end
      end
    end
  end

  // End the run when no word moves on any channel for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    logic [15:0] w_data, h_data;
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = REG_IMAGE_WIDTH;
    cfg_data      = '0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    send_idle_max = 14;
    recv_idle_max = 14;
    foreach (line_store[i]) line_store[i] = 0;
    prev0      = 0;
    prev1      = 0;
    col_pos    = 0;
    row_pos    = 0;
    width_reg  = 13'd2;
    height_reg = 16'd2;

    // Sizes below 2 act as 2: two 2x2 images with extreme and all-ones samples.
    directed_rows.push_back(write_row(REG_IMAGE_WIDTH, 16'h0000));
    directed_rows.push_back(write_row(REG_IMAGE_HEIGHT, 16'h0001));
    directed_rows.push_back(sample_row(16'h8000));
    directed_rows.push_back(sample_row(16'h7FFF));
    directed_rows.push_back(sample_row(16'h7FFF));
    directed_rows.push_back(closing_row(16'h8000, 196606, -196604, -196604, 196606));
    directed_rows.push_back(write_row(REG_IMAGE_WIDTH, 16'h0001));
    directed_rows.push_back(write_row(REG_IMAGE_HEIGHT, 16'h0000));
    // writes past the last register must not touch the size
    directed_rows.push_back(write_row(REG_SPARE_2, 16'hFFFF));
    directed_rows.push_back(write_row(REG_SPARE_3, 16'hFFFF));
    directed_rows.push_back(sample_row(16'hFFFF));
    directed_rows.push_back(sample_row(16'hFFFF));
    directed_rows.push_back(sample_row(16'hFFFF));
    directed_rows.push_back(closing_row(16'hFFFF, 2, 2, 2, 2));
    // 3x4 image: pixel (1,1) reaches the top of the range, (1,2) the bottom
    directed_rows.push_back(write_row(REG_IMAGE_WIDTH, 16'd3));
    directed_rows.push_back(write_row(REG_IMAGE_HEIGHT, 16'd4));
    directed_rows.push_back(sample_row(16'h0000));
    directed_rows.push_back(sample_row(16'h7FFF));
    directed_rows.push_back(sample_row(16'h0000));
    directed_rows.push_back(sample_row(16'h7FFF));
    directed_rows.push_back(sample_row(16'h8000));
    directed_rows.push_back(sample_row(16'h7FFF));
    directed_rows.push_back(sample_row(16'h8000));
    directed_rows.push_back(sample_row(16'h7FFF));
    directed_rows.push_back(sample_row(16'h8000));
    directed_rows.push_back(sample_row(16'h0000));
    directed_rows.push_back(sample_row(16'h8000));
    directed_rows.push_back(sample_row(16'h0000));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == STIM_WRITE) begin
        settle_idle();
        write_register(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        feed_sample(directed_rows[i].data, directed_rows[i].has_lap, directed_rows[i].lap);
      end
    end

    // Random images of small sizes; upper width bits fall outside the register.
    for (int phase = 0; phase < 8; phase++) begin
      w_data = 16'($urandom_range(2, 9)) | 16'($urandom_range(0, 7) << 13);
      h_data = 16'($urandom_range(2, 6));
      case (phase)
        1: w_data = 16'($urandom_range(0, 1));
        2: h_data = 16'($urandom_range(0, 1));
        5: begin
          w_data = 16'd16;
          h_data = 16'd2;
        end
        7: begin
          w_data = 16'd2;
          h_data = 16'd2;
        end
        default: ;
      endcase
      send_idle_max = (phase % 4 == 3) ? 0 : 14;
      recv_idle_max = (phase % 3 == 2) ? 0 : 14;
      run_images(w_data, h_data);
    end
    send_idle_max = 14;
    recv_idle_max = 14;

    // Width shrunk mid-row: column 6 of row 1 clamps to the new last column.
    run_images(16'd8, 16'd4);
    feed_random(14);
    settle_idle();
    write_register(REG_IMAGE_WIDTH, 16'd4);
    feed_random(9);

    // Tallest height, then shrunk below the current row: row 3 acts as the last row.
    settle_idle();
    write_register(REG_IMAGE_WIDTH, 16'd4);
    write_register(REG_IMAGE_HEIGHT, 16'hFFFF);
    feed_random(12);
    settle_idle();
    write_register(REG_IMAGE_WIDTH, 16'd2);
    write_register(REG_IMAGE_HEIGHT, 16'd2);
    write_register(REG_IMAGE_WIDTH, 16'd4);
    feed_random(4);

    // Width raised to the maximum and past it mid-row: the counters run on and
    // row 1 reads only the columns that row 0 wrote.
    settle_idle();
    write_register(REG_IMAGE_WIDTH, 16'd8);
    write_register(REG_IMAGE_HEIGHT, 16'd4);
    feed_random(11);
    settle_idle();
    write_register(REG_IMAGE_WIDTH, 16'd4096);
    feed_random(2);
    settle_idle();
    write_register(REG_IMAGE_WIDTH, 16'hFFFF);
    feed_random(3);

    settle_idle();
    if (fail_count == 0 && pending_laplacians.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
